[sv/mns_pkg.sv]
// ----------------------------------------------------------------------------
// mns_pkg
// Shared types and constants of the midi note sequencer: request and result
// items, configuration registers, queued messages and MIDI codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mns_pkg;

	localparam int TBL_AW      = 8;
	localparam int TABLE_DEPTH = 1 << TBL_AW;

	localparam int MSG_AW    = 2;
	localparam int MSG_DEPTH = 1 << MSG_AW;

	localparam logic [7:0] MAX_DATA = 8'd127;

	// channel 0
	localparam logic [3:0] MIDI_CHANNEL = 4'h0;
	localparam logic [7:0] ST_CTRL = {4'hB, MIDI_CHANNEL};
	localparam logic [7:0] ST_PROG = {4'hC, MIDI_CHANNEL};
	localparam logic [7:0] ST_ON   = {4'h9, MIDI_CHANNEL};
	localparam logic [7:0] ST_OFF  = {4'h8, MIDI_CHANNEL};

	localparam logic [7:0] CC_BANK    = 8'h00;
	localparam logic [7:0] CC_VOLUME  = 8'h07;
	localparam logic [7:0] CC_ALL_OFF = 8'h7B;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	localparam logic [CFG_IW-1:0] REG_LOOP_ENABLE     = 3'd0;
	localparam logic [CFG_IW-1:0] REG_REVERSE_ORDER   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_TRANSPOSE       = 3'd2;
	localparam logic [CFG_IW-1:0] REG_DUR_OFFSET      = 3'd3;
	localparam logic [CFG_IW-1:0] REG_PROGRAM_NUMBER  = 3'd4;
	localparam logic [CFG_IW-1:0] REG_CHANNEL_VOLUME  = 3'd5;
	localparam logic [CFG_IW-1:0] REG_BANK_NUMBER     = 3'd6;
	localparam logic [CFG_IW-1:0] REG_SEQUENCE_LENGTH = 3'd7;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_START = 2'd2,
		CMD_STOP  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [7:0]  entry_index;
		logic [7:0]  entry_note;
		logic [15:0] entry_duration;
	} req_t;

	typedef struct packed {
		logic [7:0] midi_byte;
		logic       last;
	} res_t;

	typedef struct packed {
		logic        loop_enable;
		logic        reverse_order;
		logic [7:0]  transpose;
		logic [15:0] dur_offset;
		logic [7:0]  program_number;
		logic [7:0]  channel_volume;
		logic [7:0]  bank_number;
		logic [8:0]  sequence_length;
	} cfg_t;

	// one queued MIDI message, two or three bytes
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       two_byte;
		logic       last;
	} msg_t;

	typedef struct packed {
		logic [7:0]  note;
		logic [15:0] duration;
	} entry_t;

endpackage

`default_nettype wire

[sv/mns_front.sv]
// ----------------------------------------------------------------------------
// mns_front
// Request intake: configuration registers, sequencer state and entry table.
// Classifies each request and pushes the MIDI messages it causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mns_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       take,
	input  wire mns_pkg::req_t              request,
	input  wire logic                       cfg_we,
	input  wire logic [mns_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [mns_pkg::CFG_DW-1:0] cfg_wdata,
	input  wire logic                       q_full,
	output logic                            q_push,
	output mns_pkg::msg_t                   q_msg,
	output logic                            front_busy
);
	import mns_pkg::*;

	typedef enum logic [1:0] {
		F_IDLE,
		F_READ,
		F_EMIT
	} fst_t;

	// message mask bits, in send order
	localparam int M_VOL  = 0;
	localparam int M_BANK = 1;
	localparam int M_PROG = 2;
	localparam int M_ON   = 3;
	localparam int M_OFF  = 4;
	localparam int M_AOFF = 5;

	fst_t        state_q;
	cfg_t        cfg_q;
	logic        playing_q;
	logic        setup_sent_q;
	logic        sounding_q;
	logic [8:0]  pos_q;
	logic [15:0] ticks_q;
	logic [5:0]  mask_q;
	logic [7:0]  note_q;

	entry_t      tbl_mem [TABLE_DEPTH];
	entry_t      tbl_rd_q;

	logic              setup_now;
	logic [8:0]        pos_a;
	logic              at_end;
	logic [8:0]        pos_b;
	logic [8:0]        slot_raw;
	logic [TBL_AW-1:0] rd_addr;
	logic [7:0]        prog_m1;
	logic [5:0]        setup_mask;
	logic [5:0]        aoff_mask;
	logic [7:0]        note_sum;
	logic [15:0]       dur_sum;
	logic [15:0]       t_cur;
	logic [15:0]       t_dec;
	logic              note_ok;
	logic [5:0]        read_mask;
	logic [5:0]        low_bit;
	logic              load_we;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{
				loop_enable: 1'b0, reverse_order: 1'b0, transpose: 8'd0,
				dur_offset: 16'd0, program_number: 8'd0,
				channel_volume: 8'd0, bank_number: 8'd0, sequence_length: 9'd1
			};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOOP_ENABLE:     cfg_q.loop_enable     <= cfg_wdata[0];
				REG_REVERSE_ORDER:   cfg_q.reverse_order   <= cfg_wdata[0];
				REG_TRANSPOSE:       cfg_q.transpose       <= cfg_wdata[7:0];
				REG_DUR_OFFSET:      cfg_q.dur_offset      <= cfg_wdata[15:0];
				REG_PROGRAM_NUMBER:  cfg_q.program_number  <= cfg_wdata[7:0];
				REG_CHANNEL_VOLUME:  cfg_q.channel_volume  <= cfg_wdata[7:0];
				REG_BANK_NUMBER:     cfg_q.bank_number     <= cfg_wdata[7:0];
				REG_SEQUENCE_LENGTH: cfg_q.sequence_length <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// position and table slot for a tick in the idle state
	always_comb begin
		setup_now = !setup_sent_q;
		pos_a     = setup_now ? 9'd0 : pos_q;
		at_end    = !sounding_q && (pos_a >= cfg_q.sequence_length);
		pos_b     = at_end ? 9'd0 : pos_a;
		slot_raw  = cfg_q.reverse_order ? (cfg_q.sequence_length - pos_b - 9'd1) : pos_b;
		rd_addr   = slot_raw[TBL_AW-1:0];
		prog_m1   = cfg_q.program_number - 8'd1;
		setup_mask         = '0;
		setup_mask[M_VOL]  = setup_now && (cfg_q.channel_volume <= MAX_DATA);
		setup_mask[M_BANK] = setup_now && (cfg_q.bank_number <= MAX_DATA);
		setup_mask[M_PROG] = setup_now && (prog_m1 <= MAX_DATA);
		aoff_mask          = '0;
		aoff_mask[M_AOFF]  = playing_q && sounding_q;
	end

	// note timing once the entry is read
	always_comb begin
		note_sum = tbl_rd_q.note + cfg_q.transpose;
		dur_sum  = tbl_rd_q.duration + cfg_q.dur_offset;
		t_cur    = sounding_q ? ticks_q : dur_sum;
		t_dec    = t_cur - 16'd1;
		note_ok  = (note_sum <= MAX_DATA) && (cfg_q.channel_volume <= MAX_DATA);
		read_mask        = '0;
		read_mask[M_ON]  = !sounding_q && note_ok;
		read_mask[M_OFF] = (t_dec == 16'd0) && note_ok;
	end

	assign load_we = take && (state_q == F_IDLE) && (request.command == CMD_LOAD);

	// entry table, one write and one registered read port
	always_ff @(posedge clk) begin
		if (load_we) begin
			tbl_mem[request.entry_index[TBL_AW-1:0]] <= '{
				note: request.entry_note, duration: request.entry_duration
			};
		end
		tbl_rd_q <= tbl_mem[rd_addr];
	end

	// message builder for the lowest pending mask bit
	always_comb begin
		low_bit = mask_q & (~mask_q + 6'd1);
		q_msg   = '{b0: ST_CTRL, b1: CC_ALL_OFF, b2: 8'h00, two_byte: 1'b0, last: 1'b0};
		priority if (low_bit[M_VOL]) begin
			q_msg.b1 = CC_VOLUME;
			q_msg.b2 = cfg_q.channel_volume;
		end else if (low_bit[M_BANK]) begin
			q_msg.b1 = CC_BANK;
			q_msg.b2 = cfg_q.bank_number;
		end else if (low_bit[M_PROG]) begin
			q_msg.b0       = ST_PROG;
			q_msg.b1       = prog_m1;
			q_msg.two_byte = 1'b1;
		end else if (low_bit[M_ON]) begin
			q_msg.b0 = ST_ON;
			q_msg.b1 = note_q;
			q_msg.b2 = cfg_q.channel_volume;
		end else if (low_bit[M_OFF]) begin
			q_msg.b0 = ST_OFF;
			q_msg.b1 = note_q;
			q_msg.b2 = cfg_q.channel_volume;
		end else begin
		end
		q_msg.last = ((mask_q & ~low_bit) == 6'd0);
	end

	assign q_push     = (state_q == F_EMIT) && (mask_q != 6'd0) && !q_full;
	assign front_busy = (state_q != F_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			playing_q    <= 1'b0;
			setup_sent_q <= 1'b0;
			sounding_q   <= 1'b0;
			pos_q        <= 9'd0;
			ticks_q      <= 16'd0;
			mask_q       <= 6'd0;
			note_q       <= 8'd0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (take) begin
						unique case (request.command)
							CMD_TICK: begin
								if (playing_q) begin
									mask_q <= setup_mask;
									pos_q  <= pos_b;
									if (at_end && !cfg_q.loop_enable) begin
										playing_q    <= 1'b0;
										setup_sent_q <= 1'b0;
										sounding_q   <= 1'b0;
										state_q      <= F_EMIT;
									end else begin
										setup_sent_q <= 1'b1;
										state_q      <= F_READ;
									end
								end
							end
							CMD_LOAD: begin
							end
							CMD_START: begin
								mask_q       <= aoff_mask;
								playing_q    <= 1'b1;
								setup_sent_q <= 1'b0;
								sounding_q   <= 1'b0;
								pos_q        <= 9'd0;
								state_q      <= F_EMIT;
							end
							CMD_STOP: begin
								mask_q       <= aoff_mask;
								playing_q    <= 1'b0;
								setup_sent_q <= 1'b0;
								sounding_q   <= 1'b0;
								state_q      <= F_EMIT;
							end
							default: ;
						endcase
					end
				end
				F_READ: begin
					note_q  <= note_sum;
					ticks_q <= t_dec;
					mask_q  <= mask_q | read_mask;
					if (t_dec == 16'd0) begin
						sounding_q <= 1'b0;
						pos_q      <= pos_q + 9'd1;
					end else begin
						sounding_q <= 1'b1;
					end
					state_q <= F_EMIT;
				end
				F_EMIT: begin
					if (mask_q == 6'd0) begin
						state_q <= F_IDLE;
					end else if (!q_full) begin
						mask_q <= mask_q & ~low_bit;
						if (q_msg.last) begin
							state_q <= F_IDLE;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/mns_msg_fifo.sv]
// ----------------------------------------------------------------------------
// mns_msg_fifo
// Short message queue between the request front and the byte sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mns_msg_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mns_pkg::msg_t push_msg,
	input  wire logic          pop,
	output mns_pkg::msg_t      head_msg,
	output logic               full,
	output logic               empty
);
	import mns_pkg::*;

	msg_t              fifo_mem [MSG_DEPTH];
	logic [MSG_AW-1:0] wr_ptr_q;
	logic [MSG_AW-1:0] rd_ptr_q;
	logic [MSG_AW:0]   count_q;

	assign full     = (count_q == (MSG_AW + 1)'(MSG_DEPTH));
	assign empty    = (count_q == '0);
	assign head_msg = fifo_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_ptr_q] <= push_msg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/mns_tx.sv]
// ----------------------------------------------------------------------------
// mns_tx
// Byte sender: takes queued messages and puts out one MIDI byte per cycle while messages are queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mns_tx (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mns_pkg::msg_t head_msg,
	input  wire logic          empty,
	output logic               pop,
	output logic               strobe,
	output mns_pkg::res_t      result
);
	import mns_pkg::*;

	msg_t       msg_q;
	logic [1:0] cnt_q;
	logic       act_q;
	logic       at_end;

	assign at_end = (cnt_q == (msg_q.two_byte ? 2'd1 : 2'd2));
	assign pop    = !empty && (!act_q || at_end);
	assign strobe = act_q;

	always_comb begin
		unique case (cnt_q)
			2'd0:    result.midi_byte = msg_q.b0;
			2'd1:    result.midi_byte = msg_q.b1;
			2'd2:    result.midi_byte = msg_q.b2;
			default: result.midi_byte = msg_q.b2;
		endcase
		result.last = msg_q.last && at_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= 2'd0;
		end else if (act_q && !at_end) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop) begin
			act_q <= 1'b1;
			cnt_q <= 2'd0;
		end else begin
			act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			msg_q <= head_msg;
		end
	end

endmodule

`default_nettype wire

[sv/midi_note_sequencer.sv]
// ----------------------------------------------------------------------------
// midi_note_sequencer
// Step sequencer that plays a table of note and duration entries as a MIDI
// byte stream on channel 0, one step of time per tick request.
// ----------------------------------------------------------------------------
// Requests are taken on a rising edge with start high and busy low: tick,
// load entry, start or stop. Bytes leave on result, one per cycle with
// strobe high for that cycle; result.last marks the final byte of a
// request. The receiver takes every strobed byte, nothing is held back.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while busy is low, which the
// block itself does not enforce, and they take effect on the next request.
// A load entry or a tick while idle leaves busy low. A start, stop or tick
// with nothing to send holds busy high until the front is idle again. The
// first byte of a start, a stop or the end of the sequence passes the emit
// state, the message queue and the byte sender in turn; a tick that reads
// the table passes the read state first. Bytes then follow one per cycle,
// up to fourteen bytes; busy drops in the cycle after the last byte. The
// byte sender sets the rate: one byte per cycle out of a four-message queue.
// Reset clears state and registers to idle; sequence_length resets to 1.
// Table entries hold no reset value and must be loaded before play.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midi_note_sequencer (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire mns_pkg::req_t              request,
	output logic                            strobe,
	output mns_pkg::res_t                   result,
	input  wire logic                       cfg_we,
	input  wire logic [mns_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [mns_pkg::CFG_DW-1:0] cfg_wdata
);
	import mns_pkg::*;

	logic take;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	logic front_busy;
	msg_t q_msg;
	msg_t head_msg;

	assign take = start && !busy;
	assign busy = front_busy || !q_empty || strobe;

	mns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.request    (request),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_msg      (q_msg),
		.front_busy (front_busy)
	);

	mns_msg_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_msg (q_msg),
		.pop      (q_pop),
		.head_msg (head_msg),
		.full     (q_full),
		.empty    (q_empty)
	);

	mns_tx u_tx (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_msg (head_msg),
		.empty    (q_empty),
		.pop      (q_pop),
		.strobe   (strobe),
		.result   (result)
	);

endmodule

`default_nettype wire

[tb/sv/midi_note_sequencer_tb.sv]
// ----------------------------------------------------------------------------
// midi_note_sequencer_tb
// Drives load, start, stop and tick requests and the register port of the
// sequencer, predicts the MIDI byte stream each request should produce and
// checks every strobed byte and its last flag in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import mns_pkg::*;

class midi_stream_scoreboard;
	cfg_t        regs;
	bit          playing;
	bit          setup_sent;
	bit          note_sounding;
	logic [8:0]  step_pos;
	logic [15:0] ticks_left;
	logic [7:0]  note_tbl [TABLE_DEPTH];
	logic [15:0] dur_tbl [TABLE_DEPTH];
	bit          filled [TABLE_DEPTH];
	res_t        expected_bytes [$];
	int          errors;

	function new();
		regs = '0;
		regs.sequence_length = 9'd1;
		playing = 0;
		setup_sent = 0;
		note_sounding = 0;
		step_pos = '0;
		ticks_left = '0;
		errors = 0;
		foreach (filled[i]) filled[i] = 0;
	endfunction

	function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
		case (idx)
			REG_LOOP_ENABLE:     regs.loop_enable = val[0];
			REG_REVERSE_ORDER:   regs.reverse_order = val[0];
			REG_TRANSPOSE:       regs.transpose = val[7:0];
			REG_DUR_OFFSET:      regs.dur_offset = val;
			REG_PROGRAM_NUMBER:  regs.program_number = val[7:0];
			REG_CHANNEL_VOLUME:  regs.channel_volume = val[7:0];
			REG_BANK_NUMBER:     regs.bank_number = val[7:0];
			REG_SEQUENCE_LENGTH: regs.sequence_length = val[8:0];
			default: ;
		endcase
	endfunction

	function logic [TBL_AW-1:0] slot_of(logic [8:0] pos);
		logic [8:0] s;
		s = regs.reverse_order ? regs.sequence_length - pos - 9'd1 : pos;
		return s[TBL_AW-1:0];
	endfunction

	function void push_byte(logic [7:0] b);
		res_t e;
		e.midi_byte = b;
		e.last = 1'b0;
		expected_bytes.push_back(e);
	endfunction

	function void push_msg(logic [7:0] st, logic [7:0] d1, logic [7:0] d2);
		push_byte(st);
		push_byte(d1);
		push_byte(d2);
	endfunction

	function void push_note(logic [7:0] st);
		logic [7:0] n;
		n = note_tbl[slot_of(step_pos)] + regs.transpose;
		if (n <= MAX_DATA && regs.channel_volume <= MAX_DATA)
			push_msg(st, n, regs.channel_volume);
	endfunction

	function void all_notes_off();
		if (playing && note_sounding)
			push_msg(ST_CTRL, CC_ALL_OFF, 8'h00);
	endfunction

	function void advance_tick();
		logic [7:0] prog;
		if (!playing)
			return;
		if (!setup_sent) begin
			prog = regs.program_number - 8'd1;
			if (regs.channel_volume <= MAX_DATA)
				push_msg(ST_CTRL, CC_VOLUME, regs.channel_volume);
			if (regs.bank_number <= MAX_DATA)
				push_msg(ST_CTRL, CC_BANK, regs.bank_number);
			if (prog <= MAX_DATA) begin
				push_byte(ST_PROG);
				push_byte(prog);
			end
			step_pos = '0;
			setup_sent = 1;
		end
		if (!note_sounding) begin
			if (step_pos >= regs.sequence_length) begin
				if (!regs.loop_enable) begin
					playing = 0;
					setup_sent = 0;
					note_sounding = 0;
					return;
				end
				step_pos = '0;
			end
			ticks_left = dur_tbl[slot_of(step_pos)] + regs.dur_offset;
			push_note(ST_ON);
			note_sounding = 1;
		end
		ticks_left = ticks_left - 16'd1;
		if (ticks_left == 16'd0) begin
			push_note(ST_OFF);
			note_sounding = 0;
			step_pos = step_pos + 9'd1;
		end
	endfunction

	function void note_request(req_t r);
		int   n_prior;
		res_t e;
		n_prior = expected_bytes.size();
		case (r.command)
			CMD_TICK: advance_tick();
			CMD_LOAD: begin
				note_tbl[r.entry_index] = r.entry_note;
				dur_tbl[r.entry_index] = r.entry_duration;
				filled[r.entry_index] = 1;
			end
			CMD_START: begin
				all_notes_off();
				playing = 1;
				setup_sent = 0;
				note_sounding = 0;
				step_pos = '0;
			end
			CMD_STOP: begin
				all_notes_off();
				playing = 0;
				setup_sent = 0;
				note_sounding = 0;
			end
			default: ;
		endcase
		if (expected_bytes.size() > n_prior) begin
			e = expected_bytes.pop_back();
			e.last = 1'b1;
			expected_bytes.push_back(e);
		end
	endfunction

	// slot the next tick would read, if it has never been loaded
	function bit unloaded_slot_ahead(output logic [TBL_AW-1:0] s);
		logic [8:0] pos;
		s = '0;
		if (!playing)
			return 0;
		pos = setup_sent ? step_pos : 9'd0;
		if (!note_sounding && pos >= regs.sequence_length) begin
			if (!regs.loop_enable)
				return 0;
			pos = '0;
		end
		s = slot_of(pos);
		return !filled[s];
	endfunction

	function int pending();
		return expected_bytes.size();
	endfunction

	task report_mismatch(string what);
		errors++;
		if (errors <= 40)
			$display("%0t mismatch: %s", $time, what);
	endtask

	task check_byte(res_t got);
		res_t want;
		if (expected_bytes.size() == 0) begin
			report_mismatch($sformatf("byte %h last %b with nothing expected",
				got.midi_byte, got.last));
			return;
		end
		want = expected_bytes.pop_front();
		if (got.midi_byte !== want.midi_byte)
			report_mismatch($sformatf("midi_byte %h, expected %h",
				got.midi_byte, want.midi_byte));
		if (got.last !== want.last)
			report_mismatch($sformatf("last %b on byte %h, expected %b",
				got.last, got.midi_byte, want.last));
	endtask
endclass

module midi_note_sequencer_tb;

	localparam int NUM_PHASES      = 10;
	localparam int ITEMS_PER_PHASE = 30;
	localparam int WATCHDOG_LIMIT  = 2000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	req_t              request;
	logic              strobe;
	res_t              result;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_wdata;

	midi_stream_scoreboard sb;
	bit                    steady;

	midi_note_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.strobe    (strobe),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1)
			sb.check_byte(result);
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && busy === 1'b0) || strobe === 1'b1 || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("midi_note_sequencer_tb failed");
		$finish;
	end

	function automatic req_t mk_req(cmd_t c, logic [7:0] idx, logic [7:0] note,
		logic [15:0] dur);
		req_t r;
		r.command = c;
		r.entry_index = idx;
		r.entry_note = note;
		r.entry_duration = dur;
		return r;
	endfunction

	function automatic cfg_t mk_cfg(bit lp, bit rev, logic [7:0] tr, logic [15:0] off,
		logic [7:0] prog, logic [7:0] vol, logic [7:0] bank, logic [8:0] len);
		cfg_t c;
		c.loop_enable = lp;
		c.reverse_order = rev;
		c.transpose = tr;
		c.dur_offset = off;
		c.program_number = prog;
		c.channel_volume = vol;
		c.bank_number = bank;
		c.sequence_length = len;
		return c;
	endfunction

	// mostly notes that land in range and short durations after the offset
	function automatic req_t random_load(logic [TBL_AW-1:0] idx);
		req_t r;
		r.command = CMD_LOAD;
		r.entry_index = idx;
		if ($urandom_range(0, 3) != 0)
			r.entry_note = 8'($urandom_range(0, 127)) - sb.regs.transpose;
		else
			r.entry_note = 8'($urandom);
		if ($urandom_range(0, 11) != 0)
			r.entry_duration = 16'($urandom_range(1, 4)) - sb.regs.dur_offset;
		else
			r.entry_duration = 16'($urandom);
		return r;
	endfunction

	function automatic int span_in_use();
		if (sb.regs.sequence_length == 0 || sb.regs.sequence_length > TABLE_DEPTH)
			return TABLE_DEPTH;
		return int'(sb.regs.sequence_length);
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   k;
		r.entry_index = 8'($urandom);
		r.entry_note = 8'($urandom);
		r.entry_duration = 16'($urandom);
		k = $urandom_range(0, 99);
		// a very long note mostly gets cut short by a restart
		if (sb.note_sounding && sb.ticks_left > 16'd200 && k < 30)
			r.command = CMD_START;
		else if (k < 70)
			r.command = CMD_TICK;
		else if (k < 84)
			r = random_load(($urandom_range(0, 4) != 0) ?
				TBL_AW'($urandom_range(0, span_in_use() - 1)) : TBL_AW'($urandom));
		else if (k < 93)
			r.command = CMD_START;
		else
			r.command = CMD_STOP;
		return r;
	endfunction

	function automatic logic [7:0] pick_data();
		return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 127)) : 8'($urandom);
	endfunction

	function automatic cfg_t random_config(int p);
		cfg_t c;
		int   k;
		case (p)
			0: return mk_cfg(1, 1, 8'd255, 16'hFFFF, 8'd128, 8'd127, 8'd127, 9'd256);
			1: return mk_cfg(0, 0, 8'd0, 16'd0, 8'd1, 8'd0, 8'd0, 9'd1);
			2: return mk_cfg(1, 0, 8'd128, 16'd0, 8'd129, 8'd127, 8'd255, 9'd300);
			3: return mk_cfg(0, 1, 8'd7, 16'd2, 8'd0, 8'd255, 8'd128, 9'd2);
			default: ;
		endcase
		c.loop_enable = 1'($urandom);
		c.reverse_order = 1'($urandom);
		c.transpose = 8'($urandom);
		k = $urandom_range(0, 3);
		c.dur_offset = (k < 2) ? 16'd0 : (k == 2) ? 16'($urandom_range(0, 3)) :
			16'($urandom);
		c.program_number = pick_data() + 8'd1;
		c.channel_volume = pick_data();
		c.bank_number = pick_data();
		k = $urandom_range(0, 19);
		if (k < 12)
			c.sequence_length = 9'($urandom_range(1, 8));
		else if (k < 15)
			c.sequence_length = 9'($urandom_range(9, 40));
		else if (k < 17)
			c.sequence_length = 9'd256;
		else if (k == 17)
			c.sequence_length = 9'd0;
		else
			c.sequence_length = 9'($urandom_range(257, 511));
		return c;
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send(req_t r);
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_request(r);
	endtask

	// never let a tick read a table slot that was not loaded
	task automatic issue(req_t r);
		logic [TBL_AW-1:0] s;
		if (r.command == CMD_TICK && sb.unloaded_slot_ahead(s))
			send(random_load(s));
		send(r);
	endtask

	task automatic pace();
		int g;
		if ($urandom_range(0, 49) == 0) begin
			start <= 1'b0;
			do @(posedge clk); while (sb.pending() != 0);
		end else begin
			g = steady ? 0 : gap_len();
			if (g > 0) begin
				start <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	task automatic issue_paced(req_t r);
		issue(r);
		pace();
	endtask

	// drain all expected bytes and let a silent request finish
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic put_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val,
		logic [CFG_DW-1:0] mask);
		logic [CFG_DW-1:0] word;
		word = val & mask;
		if ($urandom_range(0, 3) == 0)
			word |= 16'($urandom) & ~mask;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= word;
		@(posedge clk);
		sb.write_reg(idx, word);
	endtask

	task automatic apply_config(cfg_t c);
		put_reg(REG_LOOP_ENABLE, 16'(c.loop_enable), 16'h0001);
		put_reg(REG_REVERSE_ORDER, 16'(c.reverse_order), 16'h0001);
		put_reg(REG_TRANSPOSE, 16'(c.transpose), 16'h00FF);
		put_reg(REG_DUR_OFFSET, c.dur_offset, 16'hFFFF);
		put_reg(REG_PROGRAM_NUMBER, 16'(c.program_number), 16'h00FF);
		put_reg(REG_CHANNEL_VOLUME, 16'(c.channel_volume), 16'h00FF);
		put_reg(REG_BANK_NUMBER, 16'(c.bank_number), 16'h00FF);
		put_reg(REG_SEQUENCE_LENGTH, 16'(c.sequence_length), 16'h01FF);
		cfg_we <= 1'b0;
	endtask

	task automatic run_directed();
		// idle tick and stop straight out of reset make no bytes
		issue_paced(mk_req(CMD_TICK, 8'hFF, 8'hFF, 16'hFFFF));
		issue_paced(mk_req(CMD_STOP, 8'h00, 8'h00, 16'h0000));
		settle();
		apply_config(mk_cfg(0, 0, 8'd0, 16'd0, 8'd1, 8'd127, 8'd0, 9'd3));
		issue_paced(mk_req(CMD_LOAD, 8'd0, 8'd0, 16'd1));
		issue_paced(mk_req(CMD_LOAD, 8'd1, 8'd127, 16'd2));
		issue_paced(mk_req(CMD_LOAD, 8'd2, 8'd255, 16'd1));
		issue_paced(mk_req(CMD_LOAD, 8'd255, 8'd60, 16'd1));
		issue_paced(mk_req(CMD_START, 8'd0, 8'd0, 16'd0));
		// full setup plus a one-tick note: fourteen bytes; then a two-tick note and a note out of range
		repeat (4) issue_paced(mk_req(CMD_TICK, 8'd0, 8'd0, 16'd0));
		// end of sequence without loop, then an idle tick
		repeat (2) issue_paced(mk_req(CMD_TICK, 8'd0, 8'd0, 16'd0));
		issue_paced(mk_req(CMD_START, 8'd0, 8'd0, 16'd0));
		repeat (2) issue_paced(mk_req(CMD_TICK, 8'd0, 8'd0, 16'd0));
		// restart while a note sounds
		issue_paced(mk_req(CMD_START, 8'd0, 8'd0, 16'd0));
		repeat (2) issue_paced(mk_req(CMD_TICK, 8'd0, 8'd0, 16'd0));
		issue_paced(mk_req(CMD_STOP, 8'd0, 8'd0, 16'd0));
		settle();
		// zero length with loop, reversed, transpose wrap, skipped setup messages
		apply_config(mk_cfg(1, 1, 8'd255, 16'hFFFF, 8'd0, 8'd100, 8'd128, 9'd0));
		// duration one plus offset wraps to zero: a note of 65536 ticks
		issue_paced(mk_req(CMD_LOAD, 8'd255, 8'd61, 16'd1));
		issue_paced(mk_req(CMD_START, 8'd0, 8'd0, 16'd0));
		repeat (2) issue_paced(mk_req(CMD_TICK, 8'd0, 8'd0, 16'd0));
		issue_paced(mk_req(CMD_STOP, 8'd0, 8'd0, 16'd0));
		settle();
	endtask

	initial begin
		cfg_t c;
		int   span;
		sb = new();
		steady = 0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (int p = 0; p < NUM_PHASES; p++) begin
			c = random_config(p);
			apply_config(c);
			steady = ($urandom_range(0, 3) == 0);
			// a fresh sequence first, then mixed requests
			span = span_in_use();
			for (int i = 0; i < span && i < 6; i++)
				issue_paced(random_load(sb.slot_of(9'(i))));
			issue_paced(mk_req(CMD_START, 8'($urandom), 8'($urandom), 16'($urandom)));
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				issue_paced(random_request());
			settle();
		end

		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("midi_note_sequencer_tb passed");
		else
			$display("midi_note_sequencer_tb failed");
		$finish;
	end

endmodule

[filelist.f]
sv/mns_pkg.sv
sv/mns_front.sv
sv/mns_msg_fifo.sv
sv/mns_tx.sv
sv/midi_note_sequencer.sv
tb/sv/midi_note_sequencer_tb.sv
